// ----- rtl/core/hex_dump_formatter_core_assert.svh -----
// Assertion macros for the hex dump formatter core.
// HDF_ASSERT expects clk_i and rst_ni, HDF_ASSERT_ALWAYS only clk_i, in the scope where it is used.
`ifndef HEX_DUMP_FORMATTER_CORE_ASSERT_SVH
`define HEX_DUMP_FORMATTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked at every rising clock edge outside of reset.
`define HDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define HDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define HDF_ASSERT(lbl, prop, msg)
`define HDF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/hdf_pkg.sv -----
`timescale 1ns / 1ps

package hdf_pkg;

  localparam int unsigned UPC_W = 4;

  // Microprogram step addresses.
  localparam logic [UPC_W-1:0] ST_NL     = 4'd0;
  localparam logic [UPC_W-1:0] ST_OFF    = 4'd1;
  localparam logic [UPC_W-1:0] ST_SP_A   = 4'd2;
  localparam logic [UPC_W-1:0] ST_SP_B   = 4'd3;
  localparam logic [UPC_W-1:0] ST_HALF   = 4'd4;
  localparam logic [UPC_W-1:0] ST_HI     = 4'd5;
  localparam logic [UPC_W-1:0] ST_LO     = 4'd6;
  localparam logic [UPC_W-1:0] ST_SEP    = 4'd7;
  localparam logic [UPC_W-1:0] ST_PADH   = 4'd8;
  localparam logic [UPC_W-1:0] ST_PAD_A  = 4'd9;
  localparam logic [UPC_W-1:0] ST_PAD_B  = 4'd10;
  localparam logic [UPC_W-1:0] ST_PAD_C  = 4'd11;
  localparam logic [UPC_W-1:0] ST_BAR_SP = 4'd12;
  localparam logic [UPC_W-1:0] ST_BAR_L  = 4'd13;
  localparam logic [UPC_W-1:0] ST_PRV    = 4'd14;
  localparam logic [UPC_W-1:0] ST_BAR_R  = 4'd15;

  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_BAR   = 7'h7C;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_OFF,
    SRC_HI,
    SRC_LO,
    SRC_PRV
  } src_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NL,
    COND_HALF_POS,
    COND_HALF_IDX
  } cond_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_MID,
    BR_DIG,
    BR_CLOSE,
    BR_PAD,
    BR_CLR,
    BR_PRV,
    BR_END
  } br_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_POS1,
    IDX_INC,
    IDX_CLR
  } idx_op_e;

  typedef struct packed {
    src_e             src;
    logic [6:0]       lit;
    cond_e            cond;
    br_e              br;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [6:0] lit;
    logic       last;
    idx_op_e    idx_op;
    logic       dig_dec;
    logic       done;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic pos_zero;
    logic past_first;
    logic pos_half;
    logic pos_last;
    logic close;
    logic idx_half;
    logic idx_last;
    logic idx_eq_pos;
    logic dig_zero;
  } stat_t;

  function automatic uword_t uw(src_e s, logic [6:0] l, cond_e c, br_e b,
                                logic [UPC_W-1:0] t);
    uword_t w;
    w.src  = s;
    w.lit  = l;
    w.cond = c;
    w.br   = b;
    w.tgt  = t;
    return w;
  endfunction

  // The microprogram: one control word per step.
  function automatic uword_t ucode(logic [UPC_W-1:0] step);
    uword_t w;
    case (step)
      ST_NL:     w = uw(SRC_LIT, CH_NL,    COND_NL,       BR_MID,   ST_HALF);
      ST_OFF:    w = uw(SRC_OFF, CH_SPACE, COND_ALWAYS,   BR_DIG,   ST_OFF);
      ST_SP_A:   w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_SP_B:   w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_HALF:   w = uw(SRC_LIT, CH_SPACE, COND_HALF_POS, BR_NEXT,  ST_NL);
      ST_HI:     w = uw(SRC_HI,  CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_LO:     w = uw(SRC_LO,  CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_SEP:    w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_CLOSE, ST_BAR_SP);
      ST_PADH:   w = uw(SRC_LIT, CH_SPACE, COND_HALF_IDX, BR_NEXT,  ST_NL);
      ST_PAD_A:  w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_PAD_B:  w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_PAD_C:  w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_PAD,   ST_PADH);
      ST_BAR_SP: w = uw(SRC_LIT, CH_SPACE, COND_ALWAYS,   BR_NEXT,  ST_NL);
      ST_BAR_L:  w = uw(SRC_LIT, CH_BAR,   COND_ALWAYS,   BR_CLR,   ST_NL);
      ST_PRV:    w = uw(SRC_PRV, CH_DOT,   COND_ALWAYS,   BR_PRV,   ST_PRV);
      ST_BAR_R:  w = uw(SRC_LIT, CH_BAR,   COND_ALWAYS,   BR_END,   ST_NL);
      default:   w = uw(SRC_LIT, CH_BAR,   COND_ALWAYS,   BR_END,   ST_NL);
    endcase
    return w;
  endfunction

  function automatic logic [6:0] hex_char(logic [3:0] nib);
    logic [6:0] n;
    n = {3'b000, nib};
    return (nib < 4'd10) ? (7'h30 + n) : (7'h57 + n);
  endfunction

  function automatic logic [6:0] preview_char(logic [7:0] v);
    return (v >= PRINT_LO && v <= PRINT_HI) ? v[6:0] : CH_DOT;
  endfunction

endpackage

// ----- rtl/core/hdf_seq.sv -----
`timescale 1ns / 1ps

module hdf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            adv_i,
  input  hdf_pkg::stat_t  stat_i,
  output hdf_pkg::ctrl_t  ctrl_o
);
  import hdf_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           word;
  logic             emit;

  assign word = ucode(upc_q);

  always_comb begin
    case (word.cond)
      COND_ALWAYS:   emit = 1'b1;
      COND_NL:       emit = stat_i.pos_zero && stat_i.past_first;
      COND_HALF_POS: emit = stat_i.pos_half;
      COND_HALF_IDX: emit = stat_i.idx_half;
      default:       emit = 1'b0;
    endcase
  end

  // Branch decision: the word names the kind of jump and its target.
  always_comb begin
    upc_d          = upc_q + UPC_W'(1);
    ctrl_o.emit    = emit;
    ctrl_o.src     = word.src;
    ctrl_o.lit     = word.lit;
    ctrl_o.idx_op  = IDX_HOLD;
    ctrl_o.dig_dec = 1'b0;
    ctrl_o.done    = 1'b0;
    case (word.br)
      BR_NEXT: ;
      BR_MID: begin
        if (!stat_i.pos_zero) upc_d = word.tgt;
      end
      BR_DIG: begin
        if (!stat_i.dig_zero) begin
          upc_d          = word.tgt;
          ctrl_o.dig_dec = 1'b1;
        end
      end
      BR_CLOSE: begin
        if (!stat_i.close) begin
          ctrl_o.done = 1'b1;
        end else if (stat_i.pos_last) begin
          upc_d = word.tgt;
        end else begin
          ctrl_o.idx_op = IDX_POS1;
        end
      end
      BR_PAD: begin
        if (!stat_i.idx_last) begin
          upc_d         = word.tgt;
          ctrl_o.idx_op = IDX_INC;
        end
      end
      BR_CLR: ctrl_o.idx_op = IDX_CLR;
      BR_PRV: begin
        if (!stat_i.idx_eq_pos) begin
          upc_d         = word.tgt;
          ctrl_o.idx_op = IDX_INC;
        end
      end
      BR_END:  ctrl_o.done = 1'b1;
      default: ctrl_o.done = 1'b1;
    endcase
    ctrl_o.last = ctrl_o.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_NL;
    end else if (start_i) begin
      upc_q <= ST_NL;
    end else if (adv_i) begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- rtl/core/hdf_dp.sv -----
`timescale 1ns / 1ps

module hdf_dp #(
  parameter int unsigned ROW_BYTES     = 16,
  parameter int unsigned OFFSET_DIGITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [7:0]      byte_i,
  input  logic            final_i,
  input  logic            adv_i,
  input  hdf_pkg::ctrl_t  ctrl_i,
  output hdf_pkg::stat_t  stat_o,
  output logic [6:0]      char_o,
  output logic            final_o,
  output logic            wrapped_o
);
  import hdf_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROW_BYTES);
  localparam int unsigned DIG_W = $clog2(OFFSET_DIGITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_BYTES - 1);
  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(ROW_BYTES / 2);
  localparam logic [DIG_W-1:0] DIG_TOP  = DIG_W'(OFFSET_DIGITS - 1);

  logic [7:0]       row_store [ROW_BYTES];
  logic [7:0]       byte_q;
  logic             final_q;
  logic             wflag_q;
  logic [IDX_W-1:0] pos_q;
  logic [IDX_W-1:0] idx_q;
  logic [DIG_W-1:0] dig_q;
  logic [31:0]      offset_q;
  logic             past_q;
  logic             wrap_q;
  logic [3:0]       off_nib;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_store[pos_q] <= byte_i;
      byte_q           <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q  <= 1'b0;
      wflag_q  <= 1'b0;
      pos_q    <= '0;
      idx_q    <= '0;
      dig_q    <= '0;
      offset_q <= '0;
      past_q   <= 1'b0;
      wrap_q   <= 1'b0;
    end else if (start_i) begin
      final_q <= final_i;
      wflag_q <= wrap_q || (&offset_q);
      dig_q   <= DIG_TOP;
    end else if (adv_i) begin
      case (ctrl_i.idx_op)
        IDX_POS1: idx_q <= pos_q + IDX_W'(1);
        IDX_INC:  idx_q <= idx_q + IDX_W'(1);
        IDX_CLR:  idx_q <= '0;
        default:  idx_q <= idx_q;
      endcase
      if (ctrl_i.dig_dec) dig_q <= dig_q - DIG_W'(1);
      if (ctrl_i.done) begin
        if (final_q) begin
          pos_q    <= '0;
          offset_q <= '0;
          past_q   <= 1'b0;
          wrap_q   <= 1'b0;
        end else begin
          offset_q <= offset_q + 32'd1;
          wrap_q   <= wflag_q;
          if (pos_q == LAST_IDX) begin
            pos_q  <= '0;
            past_q <= 1'b1;
          end else begin
            pos_q <= pos_q + IDX_W'(1);
          end
        end
      end
    end
  end

  assign off_nib = offset_q[{dig_q, 2'b00} +: 4];

  always_comb begin
    case (ctrl_i.src)
      SRC_LIT: char_o = ctrl_i.lit;
      SRC_OFF: char_o = hex_char(off_nib);
      SRC_HI:  char_o = hex_char(byte_q[7:4]);
      SRC_LO:  char_o = hex_char(byte_q[3:0]);
      SRC_PRV: char_o = preview_char(row_store[idx_q]);
      default: char_o = ctrl_i.lit;
    endcase
  end

  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.past_first = past_q;
  assign stat_o.pos_half   = (pos_q == HALF_IDX);
  assign stat_o.pos_last   = (pos_q == LAST_IDX);
  assign stat_o.close      = final_q || (pos_q == LAST_IDX);
  assign stat_o.idx_half   = (idx_q == HALF_IDX);
  assign stat_o.idx_last   = (idx_q == LAST_IDX);
  assign stat_o.idx_eq_pos = (idx_q == pos_q);
  assign stat_o.dig_zero   = (dig_q == '0);

  assign final_o   = final_q;
  assign wrapped_o = wflag_q;

endmodule

// ----- rtl/core/hex_dump_formatter_core.sv -----
`timescale 1ns / 1ps

// Hex dump formatter. Bytes enter on the s_axis channel (tdata = the byte,
// tlast = last byte of the stream) and the canonical dump text leaves on the
// m_axis channel, one ASCII character per transfer. On the output, tlast marks
// the last character caused by one input byte, tuser[0] the last character of
// the whole dump and tuser[1] that the 32-bit offset counter has wrapped.
// A byte is accepted, then a 16-step microprogram runs one step per cycle while
// the output register has room, each step yielding at most one character. A
// byte in the middle of a row runs 5 steps; the first byte of a row adds
// OFFSET_DIGITS + 2 steps for the offset and the two spaces after it, and the
// byte that closes a row adds four steps per missing byte for the padding,
// three for the bars and the space before them and one per row byte for the
// preview. s_axis_tready_o is high whenever no byte is in work, so the next
// byte is taken while the last character of the previous one still waits in
// the output register. When the receiver stalls, the sequencer holds its step
// until the output register frees up. Reset clears the offset, row position
// and flags, as does the byte marked last, so a new dump starts.
module hex_dump_formatter_core #(
  parameter int unsigned ROW_BYTES     = 16,
  parameter int unsigned OFFSET_DIGITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,  // final_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [6:0] text_char, [7] zero
  output logic       m_axis_tlast_o,  // run_end
  output logic [1:0] m_axis_tuser_o   // [0] dump_end, [1] offset_wrapped
);
  import hdf_pkg::*;

  `include "hex_dump_formatter_core_assert.svh"

  ctrl_t      ctrl;
  stat_t      stat;
  logic       busy_q;
  logic       start;
  logic       adv;
  logic       load;
  logic [6:0] char_d;
  logic       byte_final;
  logic       wrapped;

  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       out_run_end_q;
  logic       out_dump_end_q;
  logic       out_wrapped_q;

  assign s_axis_tready_o = !busy_q;
  assign start           = s_axis_tvalid_i && !busy_q;
  // A step moves on only if the output register has room, whether or not it emits a character.
  assign adv             = busy_q && (!out_valid_q || m_axis_tready_i);
  assign load            = adv && ctrl.emit;

  hdf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .adv_i   (adv),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  hdf_dp #(
    .ROW_BYTES     (ROW_BYTES),
    .OFFSET_DIGITS (OFFSET_DIGITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .byte_i    (s_axis_tdata_i),
    .final_i   (s_axis_tlast_i),
    .adv_i     (adv),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .char_o    (char_d),
    .final_o   (byte_final),
    .wrapped_o (wrapped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
      end else if (adv && ctrl.done) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q     <= char_d;
      out_run_end_q  <= ctrl.last;
      out_dump_end_q <= ctrl.last && byte_final;
      out_wrapped_q  <= wrapped;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_run_end_q;
  assign m_axis_tuser_o  = {out_wrapped_q, out_dump_end_q};

  // The last step of a byte always produces a character that closes the run.
  `HDF_ASSERT(a_done_emits, (adv && ctrl.done) |-> (ctrl.emit && ctrl.last), "no closing char")
  // Characters come only out of a running microprogram.
  `HDF_ASSERT(a_load_busy, load |-> $past(busy_q) || busy_q, "character loaded while idle")
  // An accepted byte starts the sequencer on the next cycle.
  `HDF_ASSERT(a_start_busy, start |=> busy_q, "accepted byte did not start the sequencer")
  // The end of the dump is always also the end of a byte's run.
  `HDF_ASSERT(a_dump_run, (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o, "bad tlast")

endmodule
